// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/u8ucs2_pkg.sv =====
package u8ucs2_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_UNIT    = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_END_ERR = 2'd3
  } status_t;

  // lead byte classes
  localparam logic [7:0] LEAD3_MASK  = 8'hf0;
  localparam logic [7:0] LEAD3_MATCH = 8'he0;
  localparam logic [7:0] LEAD2_MASK  = 8'he0;
  localparam logic [7:0] LEAD2_MATCH = 8'hc0;
  localparam logic [7:0] CONT_FLIP   = 8'h80;
  localparam logic [7:0] LEAD3_BITS  = 8'h0f;
  localparam logic [7:0] LEAD2_BITS  = 8'h1f;

  // sequence lengths
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO  = 2'd2;
  localparam logic [1:0] SEQ_THREE = 2'd3;

endpackage

// ===== rtl/utf8_to_ucs2_decoder_unit.sv =====
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | data_byte, buffer_end
// output  | out_valid | out_stall | code_unit, status, end_of_buffer
//
// one byte accepted per cycle while in_stall is low; a byte passes through an input
// register and the decode logic into the output register
// the decode state advances as the input register drains into the output stage
// rst is synchronous, active high, and clears the sequence state and both valids
// bytes that give no result still drain at one per cycle unless the output register is stalled
// in_stall rises only while the input register is full and the output
// register holds a result that out_stall keeps back
`include "assert_macros.svh"

module utf8_to_ucs2_decoder_unit
  import u8ucs2_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic [1:0]  status,
  output logic        end_of_buffer
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // decode state
  logic [1:0] bytes_pending;
  logic [7:0] lead_store;
  logic [7:0] middle_store;
  logic [1:0] seq_length;
  logic       dropping;

  logic [1:0] bytes_pending_next;
  logic [7:0] lead_store_next;
  logic [7:0] middle_store_next;
  logic [1:0] seq_length_next;
  logic       dropping_next;

  // decoded result for the byte in the input register
  logic        has_result;
  logic [15:0] res_unit;
  status_t     res_status;
  logic        res_end;

  logic        s1_go;
  logic        in_take;
  logic        is_lead3;
  logic        is_lead2;
  logic [7:0]  cont_bits;
  logic [7:0]  mid_bits;

  // the input register moves on when the output register is free or emptying
  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  assign is_lead3  = (s1_byte & LEAD3_MASK) == LEAD3_MATCH;
  assign is_lead2  = (s1_byte & LEAD2_MASK) == LEAD2_MATCH;
  assign cont_bits = s1_byte ^ CONT_FLIP;
  assign mid_bits  = middle_store ^ CONT_FLIP;

  always_comb begin
    bytes_pending_next = bytes_pending;
    lead_store_next    = lead_store;
    middle_store_next  = middle_store;
    seq_length_next    = seq_length;
    dropping_next      = dropping;
    has_result         = 1'b0;
    res_unit           = 16'h0000;
    res_status         = ST_UNIT;
    res_end            = s1_last;

    if (dropping) begin
      // swallow bytes until the buffer end closes the error
      if (s1_last) begin
        dropping_next      = 1'b0;
        bytes_pending_next = 2'd0;
        lead_store_next    = 8'h00;
        middle_store_next  = 8'h00;
        seq_length_next    = SEQ_NONE;
        has_result         = 1'b1;
        res_status         = ST_END_ERR;
        res_end            = 1'b1;
      end
    end else if (bytes_pending == 2'd0) begin
      if (!s1_byte[7]) begin
        // plain ascii
        has_result = 1'b1;
        res_unit   = {8'h00, s1_byte};
      end else if (is_lead3 || is_lead2) begin
        if (s1_last) begin
          has_result = 1'b1;
          res_status = ST_TRUNC;
          res_end    = 1'b1;
        end else begin
          lead_store_next    = s1_byte;
          middle_store_next  = 8'h00;
          seq_length_next    = is_lead3 ? SEQ_THREE : SEQ_TWO;
          bytes_pending_next = is_lead3 ? 2'd2 : 2'd1;
        end
      end else begin
        // bad lead byte
        dropping_next = !s1_last;
        has_result    = 1'b1;
        res_status    = ST_INVALID;
      end
    end else if (bytes_pending >= 2'd2) begin
      if (s1_last) begin
        bytes_pending_next = 2'd0;
        lead_store_next    = 8'h00;
        middle_store_next  = 8'h00;
        seq_length_next    = SEQ_NONE;
        has_result         = 1'b1;
        res_status         = ST_TRUNC;
        res_end            = 1'b1;
      end else begin
        middle_store_next  = s1_byte;
        bytes_pending_next = 2'd1;
      end
    end else begin
      // final continuation byte completes the unit
      if (seq_length == SEQ_THREE) begin
        res_unit = {(lead_store[3:0] & LEAD3_BITS[3:0]), 12'h000}
                 | {2'b00, mid_bits, 6'b000000}
                 | {8'h00, cont_bits};
      end else begin
        res_unit = {5'b00000, (lead_store[4:0] & LEAD2_BITS[4:0]), 6'b000000}
                 | {8'h00, cont_bits};
      end
      bytes_pending_next = 2'd0;
      lead_store_next    = 8'h00;
      middle_store_next  = 8'h00;
      seq_length_next    = SEQ_NONE;
      has_result         = 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_byte <= data_byte;
      s1_last <= buffer_end;
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      lead_store    <= 8'h00;
      middle_store  <= 8'h00;
      seq_length    <= SEQ_NONE;
      dropping      <= 1'b0;
    end else if (s1_go) begin
      bytes_pending <= bytes_pending_next;
      lead_store    <= lead_store_next;
      middle_store  <= middle_store_next;
      seq_length    <= seq_length_next;
      dropping      <= dropping_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= has_result;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_go && has_result) begin
      code_unit     <= res_unit;
      status        <= res_status;
      end_of_buffer <= res_end;
    end
  end

  `ASSERT_CLK(a_stall_needs_byte, in_stall |-> s1_valid && out_valid && out_stall,
              "input stalled without a held result")
  `ASSERT_CLK(a_error_unit_zero, out_valid && status != ST_UNIT |-> code_unit == 16'h0000,
              "error result carries a nonzero unit")
  `ASSERT_CLK(a_end_err_marked, out_valid && status == ST_END_ERR |-> end_of_buffer,
              "closing status without buffer end")
  `ASSERT_CLK(a_drop_no_seq, dropping |-> bytes_pending == 2'd0,
              "sequence open while dropping")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !s1_valid,
                 "pipeline not empty after reset")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8ucs2_pkg::*;

  // length of the forced receiver hold-off, in cycles
  localparam int HOLD_CYCLES    = 80;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  // idle time after the final drain, in cycles, so both registers can empty
  localparam int SETTLE_CYCLES  = 8;
  // counted input bytes per idling phase
  localparam int PHASE_ITEMS    = 600;

  // one byte of the input stream with its end-of-buffer mark
  typedef struct {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  // one decoded result as it should leave the block
  typedef struct {
    logic [15:0] unit;
    status_t     st;
    logic        eob;
  } ucs2_result_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [7:0]  data_byte  = 8'h00;
  logic        buffer_end = 1'b0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        end_of_buffer;

  utf8_beat_t   byte_q[$];     // bytes waiting to be offered
  ucs2_result_t unit_q[$];     // results the block still owes

  // stream shaping, set by the sequencer
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit send_pause    = 1'b0;
  int hold_ask      = 0;       // bumped to request one long receiver hold-off

  int n_items  = 0;            // counted bytes queued so far
  int n_errors = 0;

  // predictor copy of the decode state
  logic [1:0] cont_left;       // continuation bytes still due
  logic [7:0] lead_seen;
  logic [7:0] mid_seen;
  logic [1:0] seq_len;
  logic       skipping;        // dropping bytes after a bad lead byte

  utf8_to_ucs2_decoder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .buffer_end    (buffer_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_unit     (code_unit),
    .status        (status),
    .end_of_buffer (end_of_buffer)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // predictor: advance the decode state by one accepted byte and queue the
  // result it owes, if any
  // -------------------------------------------------------------------------
  task automatic decode_byte(input logic [7:0] b, input logic last);
    ucs2_result_t r;
    bit           gives;
    gives = 1'b0;
    r     = '{unit: 16'h0000, st: ST_UNIT, eob: last};
    if (skipping) begin
      // everything up to the buffer end is swallowed, then one closing status
      if (last) begin
        skipping  = 1'b0;
        cont_left = 2'd0;
        lead_seen = 8'h00;
        mid_seen  = 8'h00;
        seq_len   = SEQ_NONE;
        r         = '{unit: 16'h0000, st: ST_END_ERR, eob: 1'b1};
        gives     = 1'b1;
      end
    end else if (cont_left == 2'd0) begin
      if (!b[7]) begin
        // plain ascii passes straight through
        r.unit = {8'h00, b};
        gives  = 1'b1;
      end else if ((b & LEAD3_MASK) == LEAD3_MATCH || (b & LEAD2_MASK) == LEAD2_MATCH) begin
        if (last) begin
          // lead byte as the last of the buffer
          r     = '{unit: 16'h0000, st: ST_TRUNC, eob: 1'b1};
          gives = 1'b1;
        end else begin
          lead_seen = b;
          mid_seen  = 8'h00;
          seq_len   = ((b & LEAD3_MASK) == LEAD3_MATCH) ? SEQ_THREE : SEQ_TWO;
          cont_left = seq_len - 2'd1;
        end
      end else begin
        // stray continuation or four-byte-and-up lead
        if (!last) skipping = 1'b1;
        r     = '{unit: 16'h0000, st: ST_INVALID, eob: last};
        gives = 1'b1;
      end
    end else if (cont_left >= 2'd2) begin
      if (last) begin
        cont_left = 2'd0;
        lead_seen = 8'h00;
        mid_seen  = 8'h00;
        seq_len   = SEQ_NONE;
        r         = '{unit: 16'h0000, st: ST_TRUNC, eob: 1'b1};
        gives     = 1'b1;
      end else begin
        mid_seen  = b;
        cont_left = 2'd1;
      end
    end else begin
      // final continuation: no check on its top bits, only the flip and the or
      if (seq_len == SEQ_THREE)
        r.unit = (16'(lead_seen & LEAD3_BITS) << 12)
               | (16'(mid_seen ^ CONT_FLIP) << 6)
               | 16'(b ^ CONT_FLIP);
      else
        r.unit = (16'(lead_seen & LEAD2_BITS) << 6) | 16'(b ^ CONT_FLIP);
      cont_left = 2'd0;
      lead_seen = 8'h00;
      mid_seen  = 8'h00;
      seq_len   = SEQ_NONE;
      gives     = 1'b1;
    end
    if (gives) unit_q.push_back(r);
  endtask

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input logic last, input bit counted = 1'b1);
    utf8_beat_t it;
    it.data = b;
    it.last = last;
    byte_q.push_back(it);
    if (counted) n_items++;
  endtask

  // mostly well-formed continuation bytes, now and then anything at all
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(3) != 0) return {2'b10, 6'($urandom)};
    return 8'($urandom);
  endfunction

  task automatic put_char(input logic last);
    int cls;
    cls = $urandom_range(9);
    if (cls < 4) begin
      put_byte({1'b0, 7'($urandom)}, last);
    end else if (cls < 7) begin
      put_byte({3'b110, 5'($urandom)}, 1'b0);
      put_byte(cont_byte(), last);
    end else begin
      put_byte({4'b1110, 4'($urandom)}, 1'b0);
      put_byte(cont_byte(), 1'b0);
      put_byte(cont_byte(), last);
    end
  endtask

  // one whole buffer: mostly clean text, some cut short, some with a bad lead
  // byte and its dropped tail, some pure noise
  task automatic put_buffer();
    int         kind;
    int         n;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 70) begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) put_char(i == n - 1);
    end else if (kind < 80) begin
      n = $urandom_range(4, 0);
      repeat (n) put_char(1'b0);
      if ($urandom_range(1)) begin
        put_byte({3'b110, 5'($urandom)}, 1'b1);
      end else if ($urandom_range(1)) begin
        put_byte({4'b1110, 4'($urandom)}, 1'b1);
      end else begin
        put_byte({4'b1110, 4'($urandom)}, 1'b0);
        put_byte(cont_byte(), 1'b1);
      end
    end else if (kind < 90) begin
      n = $urandom_range(3, 0);
      repeat (n) put_char(1'b0);
      b = $urandom_range(1) ? {2'b10, 6'($urandom)} : {4'b1111, 4'($urandom)};
      if ($urandom_range(9) < 3) begin
        put_byte(b, 1'b1);
      end else begin
        put_byte(b, 1'b0);
        // dropped bytes do not count as stimulus
        repeat ($urandom_range(5)) put_byte(8'($urandom), 1'b0, 1'b0);
        put_byte(8'($urandom), 1'b1);
      end
    end else begin
      n = $urandom_range(10, 1);
      for (int i = 0; i < n; i++)
        put_byte(8'($urandom), (i == n - 1) || ($urandom_range(99) < 15));
    end
  endtask

  // -------------------------------------------------------------------------
  // driver: predicts on every input transaction, then offers the next byte
  // unless the current one is still held back
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    utf8_beat_t it;
    if (rst) begin
      in_valid   <= 1'b0;
      data_byte  <= 8'h00;
      buffer_end <= 1'b0;
      cont_left  = 2'd0;
      lead_seen  = 8'h00;
      mid_seen   = 8'h00;
      seq_len    = SEQ_NONE;
      skipping   = 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(data_byte, buffer_end);
      // a stalled byte stays put; otherwise decide afresh
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
          it = byte_q.pop_front();
          data_byte  <= it.data;
          buffer_end <= it.last;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // receiver: random stall, plus a long hold-off on request so that the
  // pipeline backs up into the input channel
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    int hold_left;
    int hold_served;
    if (rst) begin
      out_stall   <= 1'b0;
      hold_left   = 0;
      hold_served = 0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_ask != hold_served) begin
      hold_served = hold_ask;
      hold_left   = HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // monitor: every output transaction against the oldest owed result
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    ucs2_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (unit_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual unit %h status %0d eob %b",
                 $time, code_unit, status, end_of_buffer);
        n_errors++;
      end else begin
        want = unit_q.pop_front();
        if (code_unit !== want.unit) begin
          $display("%0t ns: code_unit mismatch, expected %h, actual %h",
                   $time, want.unit, code_unit);
          n_errors++;
        end
        if (status !== want.st) begin
          $display("%0t ns: status mismatch, expected %s, actual %0d",
                   $time, want.st.name(), status);
          n_errors++;
        end
        if (end_of_buffer !== want.eob) begin
          $display("%0t ns: end_of_buffer mismatch, expected %b, actual %b",
                   $time, want.eob, end_of_buffer);
          n_errors++;
        end
      end
    end
  end

  // watchdog: too long without a transaction on either channel means a hang
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles at %0t ns", quiet, $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // sequencer: reset, directed bytes, three idling phases of random buffers,
  // the pressure events, then the final drain and verdict
  // the waits after reset sit on the falling edge so nothing races the clocked blocks
  // -------------------------------------------------------------------------
  initial begin : sequencer
    int mark;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 11;
    recv_idle_pct = 60;

    // ascii extremes
    put_byte(8'h00, 1'b0);
    put_byte(8'h7f, 1'b0);
    // two-byte extremes
    put_byte(8'hc0, 1'b0); put_byte(8'h80, 1'b0);
    put_byte(8'hdf, 1'b0); put_byte(8'hbf, 1'b0);
    // three-byte extremes, the second one closing its buffer
    put_byte(8'he0, 1'b0); put_byte(8'h80, 1'b0); put_byte(8'h80, 1'b0);
    put_byte(8'hef, 1'b0); put_byte(8'hbf, 1'b0); put_byte(8'hbf, 1'b1);
    // continuation bytes outside 10xxxxxx are folded in unchecked
    put_byte(8'he5, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'hff, 1'b0);
    // stray continuation as the last byte of a buffer
    put_byte(8'h80, 1'b1);
    // bad lead mid-buffer: tail dropped, closing status on the last byte
    put_byte(8'hff, 1'b0); put_byte(8'h41, 1'b0); put_byte(8'hc3, 1'b1);
    // buffer ends on a lead byte
    put_byte(8'hc3, 1'b1);
    // buffer ends on the middle byte of a three-byte sequence
    put_byte(8'he2, 1'b0); put_byte(8'h82, 1'b1);
    // two-byte unit that closes its buffer
    put_byte(8'hd0, 1'b0); put_byte(8'h41, 1'b1);
    // four-byte lead marked last
    put_byte(8'hf0, 1'b1);
    do @(negedge clk); while (byte_q.size() != 0 || in_valid);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mark = n_items + PHASE_ITEMS;
      while (n_items < mark) put_buffer();

      if (ph == 1) begin
        // halfway through, hold the sender until the block has nothing owed
        mark = byte_q.size() / 2;
        while (byte_q.size() > mark) @(negedge clk);
        send_pause = 1'b1;
        do @(negedge clk); while (unit_q.size() != 0);
        send_pause = 1'b0;
      end else if (ph == 2) begin
        // with the sender flat out, block the output long enough to back up
        mark = (byte_q.size() * 3) / 4;
        while (byte_q.size() > mark) @(negedge clk);
        hold_ask++;
      end
      do @(negedge clk); while (byte_q.size() != 0 || in_valid);
    end

    // drain whatever is still owed, then allow the pipeline to settle
    do @(negedge clk); while (unit_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (n_errors == 0 && unit_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/u8ucs2_pkg.sv
rtl/utf8_to_ucs2_decoder_unit.sv
tb/tb_top.sv
